FILE: sv/besq_pkg.sv
// shared constants, codes and handshake types for the bounded evicting slot queue
// no dependencies; imported by every module of the block
package besq_pkg;

  // queue geometry
  localparam int CAPACITY    = 8;
  localparam int HANDLE_BITS = 32;
  localparam int IDX_W       = $clog2(CAPACITY);
  localparam int COUNT_W     = $clog2(CAPACITY + 1);

  // fixed port widths
  localparam int ACTION_W = 2;
  localparam int SLOT_W   = 3;
  localparam int ITEM_W   = 32;
  localparam int STATUS_W = 2;

  // operation codes
  typedef enum logic [ACTION_W-1:0] {
    ACT_ADD      = 2'd0,
    ACT_WITHDRAW = 2'd1,
    ACT_READ     = 2'd2,
    ACT_NOP      = 2'd3
  } action_t;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    STS_OK         = 2'd0,
    STS_BEYOND_CAP = 2'd1,
    STS_BEYOND_CNT = 2'd2,
    STS_UNUSED     = 2'd3
  } status_t;

  // controller to datapath commands
  typedef struct packed {
    logic exec;  // carry out the input beat and load the result register
  } ctl_cmd_t;

endpackage

FILE: sv/bounded_evicting_slot_queue_core.sv
// top level of the bounded evicting slot queue
// depends on besq_pkg, besq_ctl and besq_dp
//
// Ordered queue of up to eight 32-bit handles, slot 0 oldest. Each input beat
// (add, withdraw, read or no-op) yields exactly one result beat, presented in the
// cycle after it is accepted, carrying the handle, a status code, the count after
// the operation and whether the slot held an entry. The block takes one beat per
// cycle while in_stall is low: the whole shift of the entry store for an evicting
// add or a withdraw is done by a single combinational shift network. A result
// register separates the two sides, so in_stall rises only while a result is held
// and out_stall is high. After reset the queue is empty; no clearing pass is needed.
module bounded_evicting_slot_queue_core
  import besq_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [ACTION_W-1:0] in_action,
  input  logic [SLOT_W-1:0]   in_slot,
  input  logic [ITEM_W-1:0]   in_item_handle,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [ITEM_W-1:0]   out_item_out,
  output logic [STATUS_W-1:0] out_status,
  output logic [COUNT_W-1:0]  out_count_after,
  output logic                out_slot_occupied
);

  ctl_cmd_t cmd;

  // handshake control
  besq_ctl u_ctl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  // queue storage and result
  besq_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .in_action         (in_action),
    .in_slot           (in_slot),
    .in_item_handle    (in_item_handle),
    .out_item_out      (out_item_out),
    .out_status        (out_status),
    .out_count_after   (out_count_after),
    .out_slot_occupied (out_slot_occupied)
  );

endmodule

FILE: sv/besq_ctl.sv
// handshake controller: tracks whether the result register holds a beat
// depends on besq_pkg
module besq_ctl
  import besq_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  output logic     out_valid,
  input  logic     out_stall,
  output ctl_cmd_t cmd
);

  typedef enum logic [1:0] {
    ST_EMPTY = 2'b01,
    ST_HELD  = 2'b10
  } ctl_state_t;

  ctl_state_t state_r;
  ctl_state_t state_nxt;
  logic       accept;

  // input may enter unless a held result is blocked downstream
  assign out_valid = (state_r == ST_HELD);
  assign in_stall  = out_valid && out_stall;
  assign accept    = in_valid && !in_stall;
  assign cmd.exec  = accept;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_EMPTY: begin
        if (accept) state_nxt = ST_HELD;
      end
      ST_HELD: begin
        if (accept) state_nxt = ST_HELD;
        else if (!out_stall) state_nxt = ST_EMPTY;
      end
      default: state_nxt = ST_EMPTY;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_EMPTY;
    else state_r <= state_nxt;
  end

endmodule

FILE: sv/besq_dp.sv
// datapath: shift-register entry store, entry count and result register
// depends on besq_pkg; driven by besq_ctl commands
module besq_dp
  import besq_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  ctl_cmd_t            cmd,
  input  logic [ACTION_W-1:0] in_action,
  input  logic [SLOT_W-1:0]   in_slot,
  input  logic [ITEM_W-1:0]   in_item_handle,
  output logic [ITEM_W-1:0]   out_item_out,
  output logic [STATUS_W-1:0] out_status,
  output logic [COUNT_W-1:0]  out_count_after,
  output logic                out_slot_occupied
);

  logic [HANDLE_BITS-1:0] entries_r   [CAPACITY];
  logic [HANDLE_BITS-1:0] entries_nxt [CAPACITY];
  logic [HANDLE_BITS-1:0] shifted     [CAPACITY];
  logic [COUNT_W-1:0]     count_r;
  logic [COUNT_W-1:0]     count_nxt;

  logic [ITEM_W-1:0]   item_r;
  logic [STATUS_W-1:0] status_r;
  logic [COUNT_W-1:0]  count_after_r;
  logic                occupied_r;

  action_t                act;
  logic [COUNT_W-1:0]     slot_ext;
  logic [HANDLE_BITS-1:0] handle;
  logic                   full;
  logic                   beyond_cap;
  logic                   beyond_cnt;
  logic                   occupied;
  status_t                status;
  logic [HANDLE_BITS-1:0] slot_entry;
  logic [ITEM_W-1:0]      item;

  assign act        = action_t'(in_action);
  assign slot_ext   = COUNT_W'(in_slot);
  assign handle     = HANDLE_BITS'(in_item_handle);
  assign full       = (count_r >= COUNT_W'(CAPACITY));
  assign beyond_cap = (slot_ext >= COUNT_W'(CAPACITY));
  assign beyond_cnt = (slot_ext >= count_r);
  assign occupied   = !beyond_cap && !beyond_cnt;
  assign slot_entry = entries_r[IDX_W'(in_slot)];

  // every entry moved down one slot, top slot cleared
  generate
    for (genvar g = 0; g < CAPACITY; g++) begin : g_shift
      if (g == CAPACITY - 1) begin : g_top
        assign shifted[g] = '0;
      end else begin : g_mid
        assign shifted[g] = entries_r[g + 1];
      end
    end
  endgenerate

  // status and returned handle
  always_comb begin
    status = STS_OK;
    item   = '0;
    if (act == ACT_WITHDRAW || act == ACT_READ) begin
      priority if (beyond_cap) status = STS_BEYOND_CAP;
      else if (beyond_cnt) status = STS_BEYOND_CNT;
      else item = ITEM_W'(slot_entry);
    end
  end

  // store and count update
  always_comb begin
    entries_nxt = entries_r;
    count_nxt   = count_r;
    unique case (act)
      ACT_ADD: begin
        if (full) begin
          for (int i = 0; i < CAPACITY; i++) begin
            entries_nxt[i] = shifted[i];
          end
          entries_nxt[CAPACITY-1] = handle;
        end else begin
          for (int i = 0; i < CAPACITY; i++) begin
            if (COUNT_W'(i) == count_r) entries_nxt[i] = handle;
          end
          count_nxt = count_r + COUNT_W'(1);
        end
      end
      ACT_WITHDRAW: begin
        if (occupied) begin
          // close the gap above the withdrawn slot
          for (int i = 0; i < CAPACITY; i++) begin
            if (COUNT_W'(i) >= slot_ext) entries_nxt[i] = shifted[i];
          end
          count_nxt = count_r - COUNT_W'(1);
        end
      end
      ACT_READ, ACT_NOP: begin
        count_nxt = count_r;
      end
      default: count_nxt = count_r;
    endcase
  end

  // entry store, no reset: entries beyond the count are never read
  always_ff @(posedge clk) begin
    if (cmd.exec) entries_r <= entries_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) count_r <= '0;
    else if (cmd.exec) count_r <= count_nxt;
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      item_r        <= item;
      status_r      <= status;
      count_after_r <= count_nxt;
      occupied_r    <= occupied;
    end
  end

  assign out_item_out      = item_r;
  assign out_status        = status_r;
  assign out_count_after   = count_after_r;
  assign out_slot_occupied = occupied_r;

endmodule

FILE: test/testbench.sv
// self-checking testbench for bounded_evicting_slot_queue_core: directed table, then random beats
// checks each result beat against a typed row or a bench shadow queue; depends on besq_pkg
// idling on both channels varies by phase, with a full drain between phases
module testbench;
  import besq_pkg::*;

  typedef struct packed {
    logic [ITEM_W-1:0]  item;
    status_t            status;
    logic [COUNT_W-1:0] count;
    logic               occupied;
  } queue_result_t;

  typedef struct packed {
    action_t            act;
    logic [SLOT_W-1:0]  slot;
    logic [ITEM_W-1:0]  handle;
    logic               typed;
    queue_result_t      want;
  } stim_row_t;

  localparam queue_result_t NO_CHECK = '{32'h0, STS_OK, 4'd0, 1'b0};
  localparam int CYCLE_LIMIT = 200000;
  localparam int N_DIRECTED  = 22;
  localparam int N_PER_PHASE = 250;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [ACTION_W-1:0] in_action = '0;
  logic [SLOT_W-1:0]   in_slot = '0;
  logic [ITEM_W-1:0]   in_item_handle = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [ITEM_W-1:0]   out_item_out;
  logic [STATUS_W-1:0] out_status;
  logic [COUNT_W-1:0]  out_count_after;
  logic                out_slot_occupied;

  bounded_evicting_slot_queue_core u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_action         (in_action),
    .in_slot           (in_slot),
    .in_item_handle    (in_item_handle),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_item_out      (out_item_out),
    .out_status        (out_status),
    .out_count_after   (out_count_after),
    .out_slot_occupied (out_slot_occupied)
  );

  // clock, period 4
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // shadow copy of the queue
  logic [ITEM_W-1:0] shadow_store [CAPACITY];
  int                shadow_count = 0;

  queue_result_t pending_results [$];
  stim_row_t     directed_rows [N_DIRECTED];
  logic          beat_typed = 1'b0;
  queue_result_t beat_want = NO_CHECK;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int mismatches = 0;
  int cycle_count = 0;
  int beats_checked = 0;
  int n_by_action [4] = '{0, 0, 0, 0};
  int n_evictions = 0;
  int n_past_count = 0;

  // drop the entry at pos, close the gap and clear the freed slot
  function automatic void drop_entry(int pos);
    for (int i = pos + 1; i < shadow_count; i++)
      shadow_store[IDX_W'(i-1)] = shadow_store[IDX_W'(i)];
    if (shadow_count > 0) begin
      shadow_count--;
      shadow_store[IDX_W'(shadow_count)] = '0;
    end
  endfunction

  // apply one operation to the shadow queue and return the result it should give
  function automatic queue_result_t apply_queue_op(action_t act, logic [SLOT_W-1:0] slot,
                                                   logic [ITEM_W-1:0] handle);
    queue_result_t r;
    r.item     = '0;
    r.status   = STS_OK;
    r.occupied = (int'(slot) < CAPACITY) && (int'(slot) < shadow_count);
    case (act)
      ACT_ADD: begin
        if (shadow_count >= CAPACITY) begin
          drop_entry(0);
          n_evictions++;
        end
        shadow_store[IDX_W'(shadow_count)] = handle;
        shadow_count++;
      end
      ACT_WITHDRAW, ACT_READ: begin
        if (int'(slot) >= CAPACITY) begin
          r.status = STS_BEYOND_CAP;
        end else if (int'(slot) >= shadow_count) begin
          r.status = STS_BEYOND_CNT;
          n_past_count++;
        end else begin
          r.item = shadow_store[slot];
          if (act == ACT_WITHDRAW) drop_entry(int'(slot));
        end
      end
      default: ;
    endcase
    r.count = COUNT_W'(shadow_count);
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [ITEM_W-1:0] got, logic [ITEM_W-1:0] want);
    $display("[%0d] mismatch on %s: got 0x%0h, expected 0x%0h", cycle_count, what, got, want);
    mismatches++;
  endtask

  // scoreboard: check result beats, then predict accepted input beats
  always @(posedge clk) begin
    queue_result_t got;
    queue_result_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        got.item     = out_item_out;
        got.status   = status_t'(out_status);
        got.count    = out_count_after;
        got.occupied = out_slot_occupied;
        beats_checked++;
        if (pending_results.size() == 0) begin
          report_mismatch("result beat with none expected", got.item, '0);
        end else begin
          want = pending_results.pop_front();
          if (got.item !== want.item) report_mismatch("item_out", got.item, want.item);
          if (got.status !== want.status)
            report_mismatch("status", ITEM_W'(got.status), ITEM_W'(want.status));
          if (got.count !== want.count)
            report_mismatch("count_after", ITEM_W'(got.count), ITEM_W'(want.count));
          if (got.occupied !== want.occupied)
            report_mismatch("slot_occupied", ITEM_W'(got.occupied), ITEM_W'(want.occupied));
        end
      end
      if (in_valid && !in_stall) begin
        n_by_action[in_action]++;
        want = apply_queue_op(action_t'(in_action), in_slot, in_item_handle);
        if (beat_typed) want = beat_want;
        pending_results.push_back(want);
      end
    end
  end

  // receiver stalls
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("watchdog expired after %0d cycles", cycle_count);
      $display("Simulation FAILED");
      $finish;
    end
  end

  // present one input beat, starting and ending at a falling edge
  task automatic send_beat(input stim_row_t row);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_action      <= row.act;
    in_slot        <= row.slot;
    in_item_handle <= row.handle;
    beat_typed = row.typed;
    beat_want  = row.want;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // hold the sender off until every expected result has come back
  task automatic wait_for_drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending_results.size() != 0);
  endtask

  initial begin
    stim_row_t row;
    int pick;
    int add_bias;

    // directed rows; only the obvious ones carry a typed expectation
    // (the slot field cannot exceed capacity - 1, so beyond capacity has no input)
    directed_rows[0]  = '{ACT_READ,     3'd0, 32'h0,        1'b1,
                          '{32'h0, STS_BEYOND_CNT, 4'd0, 1'b0}};
    directed_rows[1]  = '{ACT_WITHDRAW, 3'd7, 32'h0,        1'b1,
                          '{32'h0, STS_BEYOND_CNT, 4'd0, 1'b0}};
    directed_rows[2]  = '{ACT_NOP,      3'd0, 32'h0,        1'b1,
                          '{32'h0, STS_OK, 4'd0, 1'b0}};
    directed_rows[3]  = '{ACT_ADD,      3'd0, 32'hffffffff, 1'b1,
                          '{32'h0, STS_OK, 4'd1, 1'b0}};
    directed_rows[4]  = '{ACT_READ,     3'd0, 32'h0,        1'b1,
                          '{32'hffffffff, STS_OK, 4'd1, 1'b1}};
    directed_rows[5]  = '{ACT_ADD,      3'd7, 32'h0,        1'b1,
                          '{32'h0, STS_OK, 4'd2, 1'b0}};
    directed_rows[6]  = '{ACT_ADD,      3'd0, 32'ha5a5a5a5, 1'b0, NO_CHECK};
    directed_rows[7]  = '{ACT_ADD,      3'd3, 32'h5a5a5a5a, 1'b0, NO_CHECK};
    directed_rows[8]  = '{ACT_ADD,      3'd1, 32'h00000001, 1'b0, NO_CHECK};
    directed_rows[9]  = '{ACT_ADD,      3'd2, 32'h80000000, 1'b0, NO_CHECK};
    directed_rows[10] = '{ACT_ADD,      3'd5, 32'h12345678, 1'b0, NO_CHECK};
    directed_rows[11] = '{ACT_ADD,      3'd6, 32'hdeadbeef, 1'b0, NO_CHECK};
    // full queue: read the tail, then an add evicts the oldest
    directed_rows[12] = '{ACT_READ,     3'd7, 32'h0,        1'b0, NO_CHECK};
    directed_rows[13] = '{ACT_ADD,      3'd7, 32'hcafef00d, 1'b0, NO_CHECK};
    directed_rows[14] = '{ACT_READ,     3'd0, 32'h0,        1'b0, NO_CHECK};
    // withdraw from the tail, past the count, the head and the middle
    directed_rows[15] = '{ACT_WITHDRAW, 3'd7, 32'h0,        1'b0, NO_CHECK};
    directed_rows[16] = '{ACT_WITHDRAW, 3'd7, 32'h0,        1'b0, NO_CHECK};
    directed_rows[17] = '{ACT_WITHDRAW, 3'd0, 32'h0,        1'b0, NO_CHECK};
    directed_rows[18] = '{ACT_WITHDRAW, 3'd3, 32'h0,        1'b0, NO_CHECK};
    directed_rows[19] = '{ACT_READ,     3'd4, 32'h0,        1'b0, NO_CHECK};
    directed_rows[20] = '{ACT_NOP,      3'd2, 32'hffffffff, 1'b0, NO_CHECK};
    directed_rows[21] = '{ACT_READ,     3'd6, 32'h0,        1'b0, NO_CHECK};

    for (int i = 0; i < CAPACITY; i++) shadow_store[IDX_W'(i)] = '0;

    // hold reset, then release it
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int i = 0; i < N_DIRECTED; i++) send_beat(directed_rows[i]);
    wait_for_drain();

    // random phases: no idling, sender idle, receiver stalling, both
    add_bias = 50;
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 53; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 53; end
        default: begin send_idle_pct = 14; recv_stall_pct = 14; end
      endcase
      for (int n = 0; n < N_PER_PHASE; n++) begin
        // swing between filling and emptying so every fill level is visited
        if (n % 40 == 0) add_bias = $urandom_range(1) ? 60 : 20;
        pick = $urandom_range(99);
        if (pick < add_bias) row.act = ACT_ADD;
        else if (pick < add_bias + (95 - add_bias) / 2) row.act = ACT_WITHDRAW;
        else if (pick < 95) row.act = ACT_READ;
        else row.act = ACT_NOP;
        // mostly slots that hold an entry, the rest anywhere
        if (shadow_count > 0 && $urandom_range(99) < 85)
          row.slot = SLOT_W'($urandom_range(shadow_count - 1));
        else
          row.slot = SLOT_W'($urandom_range(7));
        pick = $urandom_range(19);
        if (pick == 0) row.handle = '0;
        else if (pick == 1) row.handle = '1;
        else row.handle = $urandom;
        row.typed = 1'b0;
        row.want  = NO_CHECK;
        send_beat(row);
      end
      wait_for_drain();
    end

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    repeat (4) @(posedge clk);

    $display("covered %0d adds (%0d evicting), %0d withdraws, %0d reads, %0d no-ops",
             n_by_action[ACT_ADD], n_evictions, n_by_action[ACT_WITHDRAW],
             n_by_action[ACT_READ], n_by_action[ACT_NOP]);
    $display("%0d result beats checked, %0d refused past the count, %0d mismatches",
             beats_checked, n_past_count, mismatches);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

FILE: files.f
sv/besq_pkg.sv
sv/besq_ctl.sv
sv/besq_dp.sv
sv/bounded_evicting_slot_queue_core.sv
test/testbench.sv
